>>> hdl/ppom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppom_pkg
// Shared types and constants for the price-priority order matcher.
// ----------------------------------------------------------------------------
package ppom_pkg;

    localparam int DEF_ORDERS_PER_SIDE = 16;
    localparam int DATA_W              = 32;
    localparam int REQ_W               = 2;

    localparam logic [REQ_W-1:0] REQ_ASK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BID = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_MATCH
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] price;
        logic [DATA_W-1:0] amount;
    } order_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic pop;
        logic upd;
    } side_ctrl_t;

endpackage

>>> hdl/ppom_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppom_cell
// One slot of a sorted order chain: insert with shift right, pop with shift
// left, and amount update at the head.
// ----------------------------------------------------------------------------
module ppom_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      descend,
    input  ppom_pkg::side_ctrl_t      ctrl,
    input  logic [ppom_pkg::DATA_W-1:0] new_price,
    input  logic [ppom_pkg::DATA_W-1:0] new_amount,
    input  logic [ppom_pkg::DATA_W-1:0] upd_amount,
    input  logic                      left_ins,
    input  ppom_pkg::order_t          left,
    input  ppom_pkg::order_t          right,
    output ppom_pkg::order_t          own,
    output logic                      ins
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ppom_pkg::DATA_W-1:0] price_reg;
    logic [ppom_pkg::DATA_W-1:0] price_next;
    logic [ppom_pkg::DATA_W-1:0] amount_reg;
    logic [ppom_pkg::DATA_W-1:0] amount_next;

    // new order goes at or before this slot; equal prices stay ahead
    assign ins = !valid_reg ||
                 (descend ? (price_reg < new_price) : (price_reg > new_price));

    assign own.valid  = valid_reg;
    assign own.price  = price_reg;
    assign own.amount = amount_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        price_next  = price_reg;
        amount_next = amount_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (ins)
            begin
                if (left_ins)
                begin
                    valid_next  = left.valid;
                    price_next  = left.price;
                    amount_next = left.amount;
                end
                else
                begin
                    valid_next  = 1'b1;
                    price_next  = new_price;
                    amount_next = new_amount;
                end
            end
        end
        else if (ctrl.pop)
        begin
            valid_next  = right.valid;
            price_next  = right.price;
            amount_next = right.amount;
        end
        else if (ctrl.upd)
        begin
            amount_next = upd_amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg  <= price_next;
        amount_reg <= amount_next;
    end

endmodule

>>> hdl/ppom_side.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppom_side
// A row of order cells kept in price order; the best order sits in cell 0.
// ----------------------------------------------------------------------------
module ppom_side #(
    parameter int ORDERS_PER_SIDE = ppom_pkg::DEF_ORDERS_PER_SIDE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        descend,
    input  ppom_pkg::side_ctrl_t        ctrl,
    input  logic [ppom_pkg::DATA_W-1:0] new_price,
    input  logic [ppom_pkg::DATA_W-1:0] new_amount,
    input  logic [ppom_pkg::DATA_W-1:0] upd_amount,
    output ppom_pkg::order_t            head,
    output logic                        full
);

    ppom_pkg::order_t cell_q [ORDERS_PER_SIDE];
    logic             ins_w  [ORDERS_PER_SIDE];

    genvar i;
    generate
        for (i = 0; i < ORDERS_PER_SIDE; i++)
        begin : g_cell
            ppom_pkg::order_t     left_d;
            ppom_pkg::order_t     right_d;
            logic                 left_ins_d;
            ppom_pkg::side_ctrl_t cc;

            if (i == 0)
            begin : g_first
                assign left_d     = '0;
                assign left_ins_d = 1'b0;
                assign cc.upd     = ctrl.upd;
            end
            else
            begin : g_mid
                assign left_d     = cell_q[i-1];
                assign left_ins_d = ins_w[i-1];
                assign cc.upd     = 1'b0;
            end

            if (i == ORDERS_PER_SIDE - 1)
            begin : g_tail
                assign right_d = '0;
            end
            else
            begin : g_body
                assign right_d = cell_q[i+1];
            end

            assign cc.clear = ctrl.clear;
            assign cc.load  = ctrl.load;
            assign cc.pop   = ctrl.pop;

            ppom_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .descend    (descend),
                .ctrl       (cc),
                .new_price  (new_price),
                .new_amount (new_amount),
                .upd_amount (upd_amount),
                .left_ins   (left_ins_d),
                .left       (left_d),
                .right      (right_d),
                .own        (cell_q[i]),
                .ins        (ins_w[i])
            );
        end
    endgenerate

    assign head = cell_q[0];
    assign full = cell_q[ORDERS_PER_SIDE-1].valid;

endmodule

>>> hdl/price_priority_order_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_priority_order_matcher_core
// Sorted ask and bid books in cell chains with a head-to-head match walk.
// ----------------------------------------------------------------------------
// Load beats never raise busy.
// A run holds busy through the match walk: each walk step
// pops one ask or one bid at the chain heads, or skips an empty bid.
// Each sale is held until the next one is found, so beats leave at most one
// per cycle; the final one (or the no-trade beat) carries last and shows in
// the first cycle with busy low. Reset empties both books at once through
// the cell valid bits.
// ----------------------------------------------------------------------------
module price_priority_order_matcher_core #(
    parameter int ORDERS_PER_SIDE = ppom_pkg::DEF_ORDERS_PER_SIDE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ppom_pkg::REQ_W-1:0]  req_type,
    input  logic [ppom_pkg::DATA_W-1:0] price,
    input  logic [ppom_pkg::DATA_W-1:0] amount,
    output logic                        result_strobe,
    output logic [ppom_pkg::DATA_W-1:0] sale_price,
    output logic [ppom_pkg::DATA_W-1:0] sale_amount,
    output logic                        sale_valid,
    output logic                        dropped_orders,
    output logic                        last
);

    ppom_pkg::state_t     state_reg;
    ppom_pkg::state_t     state_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [ppom_pkg::DATA_W-1:0] pend_price_reg;
    logic [ppom_pkg::DATA_W-1:0] pend_price_next;
    logic [ppom_pkg::DATA_W-1:0] pend_amount_reg;
    logic [ppom_pkg::DATA_W-1:0] pend_amount_next;
    logic                 strobe_reg;
    logic                 strobe_next;
    logic [ppom_pkg::DATA_W-1:0] out_price_reg;
    logic [ppom_pkg::DATA_W-1:0] out_price_next;
    logic [ppom_pkg::DATA_W-1:0] out_amount_reg;
    logic [ppom_pkg::DATA_W-1:0] out_amount_next;
    logic                 out_sv_reg;
    logic                 out_sv_next;
    logic                 out_drop_reg;
    logic                 out_drop_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    ppom_pkg::side_ctrl_t ask_ctrl;
    ppom_pkg::side_ctrl_t bid_ctrl;
    ppom_pkg::order_t     ask_head;
    ppom_pkg::order_t     bid_head;
    logic                 ask_full;
    logic                 bid_full;
    logic [ppom_pkg::DATA_W-1:0] ask_upd;
    logic [ppom_pkg::DATA_W-1:0] bid_upd;

    logic accept;
    logic run_end;
    logic bid_empty;
    logic bid_ge;

    assign busy   = (state_reg != ppom_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign bid_empty = (bid_head.amount == '0);
    assign bid_ge    = (bid_head.amount >= ask_head.amount);
    assign run_end   = !ask_head.valid || !bid_head.valid ||
                       (!bid_empty && (bid_head.price < ask_head.price));
    assign ask_upd   = ask_head.amount - bid_head.amount;
    assign bid_upd   = bid_head.amount - ask_head.amount;

    ppom_side #(
        .ORDERS_PER_SIDE (ORDERS_PER_SIDE)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .descend    (1'b0),
        .ctrl       (ask_ctrl),
        .new_price  (price),
        .new_amount (amount),
        .upd_amount (ask_upd),
        .head       (ask_head),
        .full       (ask_full)
    );

    ppom_side #(
        .ORDERS_PER_SIDE (ORDERS_PER_SIDE)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .descend    (1'b1),
        .ctrl       (bid_ctrl),
        .new_price  (price),
        .new_amount (amount),
        .upd_amount (bid_upd),
        .head       (bid_head),
        .full       (bid_full)
    );

    always_comb
    begin
        state_next       = state_reg;
        overflow_next    = overflow_reg;
        pend_valid_next  = pend_valid_reg;
        pend_price_next  = pend_price_reg;
        pend_amount_next = pend_amount_reg;
        strobe_next      = 1'b0;
        out_price_next   = out_price_reg;
        out_amount_next  = out_amount_reg;
        out_sv_next      = out_sv_reg;
        out_drop_next    = out_drop_reg;
        out_last_next    = out_last_reg;
        ask_ctrl         = '0;
        bid_ctrl         = '0;

        unique case (state_reg)
            ppom_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        ppom_pkg::REQ_ASK:
                        begin
                            if (ask_full)
                                overflow_next = 1'b1;
                            else
                                ask_ctrl.load = 1'b1;
                        end
                        ppom_pkg::REQ_BID:
                        begin
                            if (bid_full)
                                overflow_next = 1'b1;
                            else
                                bid_ctrl.load = 1'b1;
                        end
                        ppom_pkg::REQ_RUN:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = ppom_pkg::ST_MATCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ppom_pkg::ST_MATCH:
            begin
                if (run_end)
                begin
                    // flush the held sale as the final beat, or report no trade
                    strobe_next     = 1'b1;
                    out_price_next  = pend_valid_reg ? pend_price_reg : '0;
                    out_amount_next = pend_valid_reg ? pend_amount_reg : '0;
                    out_sv_next     = pend_valid_reg;
                    out_drop_next   = overflow_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    overflow_next   = 1'b0;
                    ask_ctrl.clear  = 1'b1;
                    bid_ctrl.clear  = 1'b1;
                    state_next      = ppom_pkg::ST_IDLE;
                end
                else if (bid_empty)
                begin
                    bid_ctrl.pop = 1'b1;
                end
                else
                begin
                    // release the previous sale now that another follows
                    strobe_next      = pend_valid_reg;
                    out_price_next   = pend_price_reg;
                    out_amount_next  = pend_amount_reg;
                    out_sv_next      = 1'b1;
                    out_drop_next    = overflow_reg;
                    out_last_next    = 1'b0;
                    pend_valid_next  = 1'b1;
                    pend_price_next  = ask_head.price;
                    if (bid_ge)
                    begin
                        pend_amount_next = ask_head.amount;
                        ask_ctrl.pop     = 1'b1;
                        bid_ctrl.upd     = 1'b1;
                    end
                    else
                    begin
                        pend_amount_next = bid_head.amount;
                        ask_ctrl.upd     = 1'b1;
                        bid_ctrl.pop     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ppom_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppom_pkg::ST_IDLE;
            overflow_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            overflow_reg   <= overflow_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_price_reg  <= pend_price_next;
        pend_amount_reg <= pend_amount_next;
        out_price_reg   <= out_price_next;
        out_amount_reg  <= out_amount_next;
        out_sv_reg      <= out_sv_next;
        out_drop_reg    <= out_drop_next;
        out_last_reg    <= out_last_next;
    end

    assign result_strobe  = strobe_reg;
    assign sale_price     = out_price_reg;
    assign sale_amount    = out_amount_reg;
    assign sale_valid     = out_sv_reg;
    assign dropped_orders = out_drop_reg;
    assign last           = out_last_reg;

endmodule
